// ===== sv/rgb_led_fade_blink_controller_assert.svh =====
// Assertion macros used by the checker file.
`ifndef RGB_LED_FADE_BLINK_CONTROLLER_ASSERT_SVH
`define RGB_LED_FADE_BLINK_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define RLFB_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("rlfb assertion failed");

// Next-cycle implication.
`define RLFB_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("rlfb assertion failed");

`endif

// ===== sv/rlfb_pkg.sv =====
`timescale 1ns / 1ps
package rlfb_pkg;

   localparam int NCH = 3;

   localparam logic [2:0] OP_TICK      = 3'd0;
   localparam logic [2:0] OP_INTENSITY = 3'd1;
   localparam logic [2:0] OP_COLOUR    = 3'd2;
   localparam logic [2:0] OP_ANIM      = 3'd3;
   localparam logic [2:0] OP_ON        = 3'd4;
   localparam logic [2:0] OP_OFF       = 3'd5;
   localparam logic [2:0] OP_FADE      = 3'd6;

   localparam logic [7:0] ANIM_NONE  = 8'd0;
   localparam logic [7:0] ANIM_BLINK = 8'd1;
   localparam logic [7:0] ANIM_FADE  = 8'd2;

   localparam logic [1:0] CSR_BLINK_HALF = 2'd0;
   localparam logic [1:0] CSR_FADE_STEP  = 2'd1;
   localparam logic [1:0] CSR_IDLE       = 2'd2;

   localparam logic [11:0] BLINK_HALF_RESET = 12'd500;
   localparam logic [7:0]  FADE_STEP_RESET  = 8'd20;
   localparam logic [11:0] IDLE_RESET       = 12'd100;

   typedef enum logic [2:0] {
      CMD_TICK,
      CMD_INTENSITY,
      CMD_COLOUR,
      CMD_ANIM,
      CMD_ON,
      CMD_OFF,
      CMD_FADE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [23:0]  rgb;
      logic [7:0]   level;
      logic [15:0]  dur;
   } cmd_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       blank;
   } frame_type;

   typedef struct packed {
      logic [11:0] blink_half;
      logic [7:0]  fade_step;
      logic [11:0] idle_period;
   } cfg_type;

endpackage

// ===== sv/rlfb_fifo.sv =====
`timescale 1ns / 1ps
module rlfb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [IW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             wr_ok, rd_ok;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign wr_ok   = wr_en && !full;
   assign rd_ok   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_ok) begin
         wr_ptr_in = (wr_ptr_ff == IW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_ok) begin
         rd_ptr_in = (rd_ptr_ff == IW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_ok && !rd_ok) begin
         count_in = count_ff + 1'b1;
      end else if (rd_ok && !wr_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== sv/rlfb_front.sv =====
`timescale 1ns / 1ps
module rlfb_front
   import rlfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [2:0]  opcode,
   input  logic [7:0]  red_in,
   input  logic [7:0]  green_in,
   input  logic [7:0]  blue_in,
   input  logic [7:0]  level,
   input  logic [15:0] fade_duration,
   input  logic        cmd_pop,
   output logic        cmd_valid,
   output cmd_type     cmd
);
   cmd_type dec;
   logic    keep;
   logic    cmd_empty;

   // Unknown opcodes and animation codes are accepted and dropped here.
   always_comb begin
      keep      = 1'b1;
      dec.kind  = CMD_TICK;
      dec.rgb   = {red_in, green_in, blue_in};
      dec.level = level;
      dec.dur   = fade_duration;
      case (opcode)
         OP_TICK:      dec.kind = CMD_TICK;
         OP_INTENSITY: dec.kind = CMD_INTENSITY;
         OP_COLOUR:    dec.kind = CMD_COLOUR;
         OP_ANIM: begin
            dec.kind = CMD_ANIM;
            keep     = (level <= ANIM_FADE);
         end
         OP_ON:        dec.kind = CMD_ON;
         OP_OFF:       dec.kind = CMD_OFF;
         OP_FADE:      dec.kind = CMD_FADE;
         default:      keep = 1'b0;
      endcase
   end

   rlfb_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (2)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push && keep),
      .wr_data (dec),
      .full    (full),
      .rd_en   (cmd_pop),
      .rd_data (cmd),
      .empty   (cmd_empty)
   );

   assign cmd_valid = !cmd_empty;

endmodule

// ===== sv/rlfb_back.sv =====
`timescale 1ns / 1ps
module rlfb_back
   import rlfb_pkg::*;
#(
   parameter logic [23:0] DEFAULT_COLOUR = 24'hFFFFFF,
   parameter logic [7:0]  DEFAULT_LEVEL  = 8'd128
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      cmd_valid,
   input  cmd_type   cmd,
   output logic      cmd_pop,
   input  logic      out_full,
   output logic      out_push,
   output frame_type out_frame
);
   typedef enum logic [2:0] {
      S_IDLE,
      S_MIX,
      S_SUM,
      S_DIV,
      S_MUL,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      MODE_NONE  = 2'd0,
      MODE_BLINK = 2'd1,
      MODE_FADE  = 2'd2
   } mode_type;

   state_type   state_ff;
   mode_type    mode_ff;
   logic [23:0] colour_ff, origin_ff, goal_ff, frame_col_ff;
   logic [7:0]  level_ff;
   logic        lit_ff, active_ff, phase_ff, frame_on_ff;
   logic [15:0] total_ff, mix_e_ff, mix_d_ff;
   logic [16:0] done_ff;
   logic [11:0] wait_ff;
   logic [2:0]  bit_ff;
   logic [23:0] prod_a_ff [NCH];
   logic [23:0] prod_b_ff [NCH];
   logic [23:0] rem_ff    [NCH];
   logic [7:0]  quo_ff    [NCH];
   logic [15:0] scl_ff    [NCH];

   logic [23:0] mul_a    [NCH];
   logic [23:0] mul_b    [NCH];
   logic [24:0] diff     [NCH];
   logic [7:0]  q_next   [NCH];
   logic [15:0] mul_s    [NCH];
   logic [7:0]  scaled   [NCH];
   logic [23:0] div_shift;
   logic [17:0] done_sum;
   logic [16:0] done_sat;
   logic        fade_end;
   logic        new_lit;

   // Exact floor(x / 255) for 16-bit x up to 65279, where the quotient fits 8 bits.
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] s;
      s = 17'(x) + 17'(x[15:8]) + 17'd1;
      return s[15:8];
   endfunction

   assign div_shift = 24'(total_ff) << bit_ff;
   assign done_sum  = 18'(done_ff) + 18'(cfg.fade_step);
   assign done_sat  = done_sum[17] ? 17'h1FFFF : done_sum[16:0];
   assign fade_end  = (total_ff == '0) || (done_ff >= 17'(total_ff));
   assign new_lit   = (level_ff != '0) ? 1'b1 : lit_ff;

   always_comb begin
      for (int i = 0; i < NCH; i++) begin
         mul_a[i]  = 24'(origin_ff[23 - 8 * i -: 8]) * 24'(mix_d_ff);
         mul_b[i]  = 24'(goal_ff[23 - 8 * i -: 8]) * 24'(mix_e_ff);
         diff[i]   = {1'b0, rem_ff[i]} - {1'b0, div_shift};
         q_next[i] = quo_ff[i] | (diff[i][24] ? 8'd0 : (8'd1 << bit_ff));
         mul_s[i]  = 16'(frame_col_ff[23 - 8 * i -: 8]) * 16'(level_ff);
         scaled[i] = frame_on_ff ? div255(scl_ff[i]) : 8'd0;
      end
   end

   assign cmd_pop         = (state_ff == S_IDLE) && cmd_valid;
   assign out_push        = (state_ff == S_EMIT);
   assign out_frame.red   = scaled[0];
   assign out_frame.green = scaled[1];
   assign out_frame.blue  = scaled[2];
   assign out_frame.blank = !frame_on_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         mode_ff   <= MODE_NONE;
         colour_ff <= DEFAULT_COLOUR;
         origin_ff <= DEFAULT_COLOUR;
         goal_ff   <= DEFAULT_COLOUR;
         level_ff  <= DEFAULT_LEVEL;
         lit_ff    <= 1'b1;
         total_ff  <= '0;
         done_ff   <= '0;
         active_ff <= 1'b0;
         phase_ff  <= 1'b0;
         wait_ff   <= '0;
         bit_ff    <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  case (cmd.kind)
                     CMD_TICK: begin
                        if (active_ff) begin
                           if (wait_ff > 12'd1) begin
                              wait_ff <= wait_ff - 1'b1;
                           end else begin
                              case (mode_ff)
                                 MODE_BLINK: begin
                                    phase_ff     <= !phase_ff;
                                    wait_ff      <= cfg.blink_half;
                                    frame_col_ff <= colour_ff;
                                    frame_on_ff  <= !phase_ff;
                                    state_ff     <= S_MUL;
                                 end
                                 MODE_FADE: begin
                                    if (fade_end) begin
                                       colour_ff    <= goal_ff;
                                       mode_ff      <= MODE_NONE;
                                       wait_ff      <= cfg.idle_period;
                                       frame_col_ff <= goal_ff;
                                       frame_on_ff  <= lit_ff;
                                       state_ff     <= S_MUL;
                                    end else begin
                                       wait_ff     <= 12'(cfg.fade_step);
                                       done_ff     <= done_sat;
                                       mix_e_ff    <= done_ff[15:0];
                                       mix_d_ff    <= total_ff - done_ff[15:0];
                                       frame_on_ff <= lit_ff;
                                       state_ff    <= S_MIX;
                                    end
                                 end
                                 default: wait_ff <= cfg.idle_period;
                              endcase
                           end
                        end
                     end
                     CMD_INTENSITY: begin
                        level_ff <= cmd.level;
                        lit_ff   <= (cmd.level != '0);
                        if (mode_ff == MODE_NONE) begin
                           frame_col_ff <= colour_ff;
                           frame_on_ff  <= (cmd.level != '0);
                           state_ff     <= S_MUL;
                        end
                     end
                     CMD_COLOUR: begin
                        colour_ff <= cmd.rgb;
                        lit_ff    <= new_lit;
                        if (new_lit && (mode_ff == MODE_NONE)) begin
                           frame_col_ff <= cmd.rgb;
                           frame_on_ff  <= 1'b1;
                           state_ff     <= S_MUL;
                        end
                     end
                     CMD_ANIM: begin
                        mode_ff <= mode_type'(cmd.level[1:0]);
                        if (cmd.level == ANIM_NONE) begin
                           active_ff <= 1'b0;
                           if (lit_ff) begin
                              frame_col_ff <= colour_ff;
                              frame_on_ff  <= 1'b1;
                              state_ff     <= S_MUL;
                           end
                        end else if (!active_ff) begin
                           active_ff <= 1'b1;
                           phase_ff  <= 1'b0;
                           wait_ff   <= '0;
                        end
                     end
                     CMD_ON: begin
                        lit_ff <= 1'b1;
                        if (mode_ff == MODE_NONE) begin
                           frame_col_ff <= colour_ff;
                           frame_on_ff  <= 1'b1;
                           state_ff     <= S_MUL;
                        end
                     end
                     CMD_OFF: begin
                        lit_ff       <= 1'b0;
                        active_ff    <= 1'b0;
                        frame_col_ff <= colour_ff;
                        frame_on_ff  <= 1'b0;
                        state_ff     <= S_MUL;
                     end
                     CMD_FADE: begin
                        origin_ff <= colour_ff;
                        goal_ff   <= cmd.rgb;
                        total_ff  <= cmd.dur;
                        done_ff   <= '0;
                        mode_ff   <= MODE_FADE;
                        if (!active_ff) begin
                           active_ff <= 1'b1;
                           phase_ff  <= 1'b0;
                           wait_ff   <= '0;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_MIX: begin
               for (int i = 0; i < NCH; i++) begin
                  prod_a_ff[i] <= mul_a[i];
                  prod_b_ff[i] <= mul_b[i];
               end
               state_ff <= S_SUM;
            end
            S_SUM: begin
               // Sum stays at or below 255 * length, so the quotient fits 8 bits.
               for (int i = 0; i < NCH; i++) begin
                  rem_ff[i] <= prod_a_ff[i] + prod_b_ff[i];
                  quo_ff[i] <= '0;
               end
               bit_ff   <= 3'd7;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               for (int i = 0; i < NCH; i++) begin
                  if (!diff[i][24]) begin
                     rem_ff[i] <= diff[i][23:0];
                  end
                  quo_ff[i] <= q_next[i];
               end
               bit_ff <= bit_ff - 1'b1;
               if (bit_ff == '0) begin
                  frame_col_ff <= {q_next[0], q_next[1], q_next[2]};
                  state_ff     <= S_MUL;
               end
            end
            S_MUL: begin
               for (int i = 0; i < NCH; i++) begin
                  scl_ff[i] <= mul_s[i];
               end
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (!out_full) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== sv/rgb_led_fade_blink_controller.sv =====
`timescale 1ns / 1ps
// An item that makes a frame passes S_MUL and S_EMIT into the rsp_ queue, whose
// head drives the rsp_ ports; a fade frame first passes S_MIX, S_SUM and the
// radix-2 divider S_DIV, one per channel. Items without a frame are taken 1 per
// cycle while the back end is idle; the next item waits until a frame is queued.
// Reset: synchronous, active high; queues empty, defaults restored at once.
module rgb_led_fade_blink_controller
   import rlfb_pkg::*;
#(
   parameter logic [23:0] DEFAULT_COLOUR = 24'hFFFFFF,
   parameter logic [7:0]  DEFAULT_LEVEL  = 8'd128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   input  logic [7:0]  req_level,
   input  logic [15:0] req_fade_duration,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic        rsp_blank,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata
);
   cfg_type   cfg_ff;
   cmd_type   cmd;
   logic      cmd_valid, cmd_pop;
   logic      out_full, out_push;
   frame_type out_frame, rsp_frame;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blink_half  <= BLINK_HALF_RESET;
         cfg_ff.fade_step   <= FADE_STEP_RESET;
         cfg_ff.idle_period <= IDLE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BLINK_HALF: cfg_ff.blink_half  <= csr_wdata;
            CSR_FADE_STEP:  cfg_ff.fade_step   <= csr_wdata[7:0];
            CSR_IDLE:       cfg_ff.idle_period <= csr_wdata;
            default: ;
         endcase
      end
   end

   rlfb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .opcode        (req_opcode),
      .red_in        (req_red_in),
      .green_in      (req_green_in),
      .blue_in       (req_blue_in),
      .level         (req_level),
      .fade_duration (req_fade_duration),
      .cmd_pop       (cmd_pop),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd)
   );

   rlfb_back #(
      .DEFAULT_COLOUR (DEFAULT_COLOUR),
      .DEFAULT_LEVEL  (DEFAULT_LEVEL)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_frame (out_frame)
   );

   rlfb_fifo #(
      .WIDTH ($bits(frame_type)),
      .DEPTH (2)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (out_push),
      .wr_data (out_frame),
      .full    (out_full),
      .rd_en   (pop),
      .rd_data (rsp_frame),
      .empty   (empty)
   );

   assign rsp_red_out   = rsp_frame.red;
   assign rsp_green_out = rsp_frame.green;
   assign rsp_blue_out  = rsp_frame.blue;
   assign rsp_blank     = rsp_frame.blank;

endmodule

// ===== sv/rlfb_checker.sv =====
`timescale 1ns / 1ps
`include "rgb_led_fade_blink_controller_assert.svh"
module rlfb_checker (
   input logic        clock,
   input logic        reset,
   input logic        full,
   input logic        empty,
   input logic        pop,
   input logic [7:0]  rsp_red_out,
   input logic [7:0]  rsp_green_out,
   input logic [7:0]  rsp_blue_out,
   input logic        rsp_blank
);

   `RLFB_ASSERT_NOW(a_blank_is_dark, clock, reset, !empty && rsp_blank, rsp_red_out == 8'd0 && rsp_green_out == 8'd0 && rsp_blue_out == 8'd0)
   `RLFB_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, empty)
   `RLFB_ASSERT_NEXT(a_reset_not_full, clock, 1'b0, reset, !full)
   `RLFB_ASSERT_NEXT(a_rsp_holds, clock, reset, !empty && !pop, !empty && $stable(rsp_red_out) && $stable(rsp_green_out) && $stable(rsp_blue_out) && $stable(rsp_blank))

endmodule

bind rgb_led_fade_blink_controller rlfb_checker u_rlfb_checker (
   .clock         (clock),
   .reset         (reset),
   .full          (full),
   .empty         (empty),
   .pop           (pop),
   .rsp_red_out   (rsp_red_out),
   .rsp_green_out (rsp_green_out),
   .rsp_blue_out  (rsp_blue_out),
   .rsp_blank     (rsp_blank)
);

// ===== verif/rgb_led_fade_blink_controller_test.sv =====
`timescale 1ns / 1ps
module rgb_led_fade_blink_controller_test;
   import rlfb_pkg::*;

   localparam logic [23:0] START_COLOUR = 24'hFFFFFF;
   localparam logic [7:0]  START_LEVEL  = 8'd128;
   localparam logic [2:0]  OP_UNUSED    = 3'd7;
   localparam int          SETTLE_CYCLES = 24;
   localparam int          CYCLE_LIMIT   = 1000000;
   localparam int          PHASE_ITEMS   = 200;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_BLINK,
      MODE_FADE
   } anim_mode_type;

   class strip_frame_board;
      frame_type   frames_due[$];
      int unsigned errors, frames_checked, blanks, fade_frames, blink_passes, fade_ends;
      logic [11:0] blink_half, idle_wait;
      logic [7:0]  fade_step;
      logic [23:0] colour, origin, goal;
      logic [7:0]  bright;
      bit          lit, runner_on, blink_on;
      anim_mode_type mode;
      logic [15:0] total;
      logic [16:0] elapsed;
      logic [11:0] wait_left;

      function new();
         blink_half = BLINK_HALF_RESET;
         fade_step  = FADE_STEP_RESET;
         idle_wait  = IDLE_RESET;
         colour     = START_COLOUR;
         origin     = START_COLOUR;
         goal       = START_COLOUR;
         bright     = START_LEVEL;
         lit        = 1'b1;
         mode       = MODE_NONE;
         total      = '0;
         elapsed    = '0;
         runner_on  = 1'b0;
         blink_on   = 1'b0;
         wait_left  = '0;
      endfunction

      function int pending();
         return frames_due.size();
      endfunction

      function void write_reg(logic [1:0] idx, logic [11:0] val);
         case (idx)
            CSR_BLINK_HALF: blink_half = val;
            CSR_FADE_STEP: fade_step = val[7:0];
            CSR_IDLE: idle_wait = val;
            default: ;
         endcase
      endfunction

      function logic [7:0] scale(logic [7:0] c);
         int unsigned p;
         p = c * bright;
         return 8'(p / 255);
      endfunction

      function logic [7:0] blend(logic [7:0] a, logic [7:0] b, int unsigned t,
                                 int unsigned e);
         int unsigned num;
         num = a * (t - e) + b * e;
         return 8'(num / t);
      endfunction

      function void add_frame(logic [23:0] c, bit shown);
         frame_type f;
         if (shown) begin
            f.red   = scale(c[23:16]);
            f.green = scale(c[15:8]);
            f.blue  = scale(c[7:0]);
            f.blank = 1'b0;
         end else begin
            f = '0;
            f.blank = 1'b1;
            blanks++;
         end
         frames_due.push_back(f);
      endfunction

      function void start_runner();
         if (runner_on) return;
         runner_on = 1'b1;
         blink_on  = 1'b0;
         wait_left = '0;
      endfunction

      function void runner_pass();
         logic [23:0] c;
         int unsigned sum;
         case (mode)
            MODE_BLINK: begin
               blink_on  = ~blink_on;
               wait_left = blink_half;
               blink_passes++;
               add_frame(colour, blink_on);
            end
            MODE_FADE: begin
               if (total == 0 || elapsed >= total) begin
                  colour    = goal;
                  mode      = MODE_NONE;
                  wait_left = idle_wait;
                  fade_ends++;
                  add_frame(colour, lit);
               end else begin
                  c = {blend(origin[23:16], goal[23:16], total, elapsed),
                       blend(origin[15:8], goal[15:8], total, elapsed),
                       blend(origin[7:0], goal[7:0], total, elapsed)};
                  wait_left = 12'(fade_step);
                  sum = elapsed + fade_step;
                  if (sum > 'h1FFFF) sum = 'h1FFFF;
                  elapsed = 17'(sum);
                  fade_frames++;
                  add_frame(c, lit);
               end
            end
            default: wait_left = idle_wait;
         endcase
      endfunction

      // returns 0 when the block simply ignores the item
      function bit note_item(logic [2:0] op, logic [23:0] rgb, logic [7:0] lvl,
                             logic [15:0] dur);
         case (op)
            OP_TICK: begin
               if (!runner_on) return 1'b0;
               if (wait_left > 1) wait_left = wait_left - 1'b1;
               else runner_pass();
            end
            OP_INTENSITY: begin
               bright = lvl;
               lit = (lvl != 0);
               if (mode == MODE_NONE) add_frame(colour, lit);
            end
            OP_COLOUR: begin
               colour = rgb;
               if (bright > 0) lit = 1'b1;
               if (lit && mode == MODE_NONE) add_frame(colour, 1'b1);
            end
            OP_ANIM: begin
               if (lvl > ANIM_FADE) return 1'b0;
               if (lvl == ANIM_NONE) begin
                  mode = MODE_NONE;
                  runner_on = 1'b0;
                  if (lit) add_frame(colour, 1'b1);
               end else begin
                  mode = (lvl == ANIM_BLINK) ? MODE_BLINK : MODE_FADE;
                  start_runner();
               end
            end
            OP_ON: begin
               lit = 1'b1;
               if (mode == MODE_NONE) add_frame(colour, 1'b1);
            end
            OP_OFF: begin
               lit = 1'b0;
               runner_on = 1'b0;
               add_frame(colour, 1'b0);
            end
            OP_FADE: begin
               origin  = colour;
               goal    = rgb;
               total   = dur;
               elapsed = '0;
               mode    = MODE_FADE;
               start_runner();
            end
            default: return 1'b0;
         endcase
         return 1'b1;
      endfunction

      function void check_frame(frame_type got);
         frame_type want;
         if (frames_due.size() == 0) begin
            $error("frame with none expected: red %0d green %0d blue %0d blank %0d",
                   got.red, got.green, got.blue, got.blank);
            errors++;
            return;
         end
         want = frames_due.pop_front();
         frames_checked++;
         if (got.red !== want.red) begin
            $error("red_out: expected %0d, got %0d", want.red, got.red);
            errors++;
         end
         if (got.green !== want.green) begin
            $error("green_out: expected %0d, got %0d", want.green, got.green);
            errors++;
         end
         if (got.blue !== want.blue) begin
            $error("blue_out: expected %0d, got %0d", want.blue, got.blue);
            errors++;
         end
         if (got.blank !== want.blank) begin
            $error("blank: expected %0d, got %0d", want.blank, got.blank);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [2:0]  req_opcode = OP_TICK;
   logic [7:0]  req_red_in = '0;
   logic [7:0]  req_green_in = '0;
   logic [7:0]  req_blue_in = '0;
   logic [7:0]  req_level = '0;
   logic [15:0] req_fade_duration = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [7:0]  rsp_red_out, rsp_green_out, rsp_blue_out;
   logic        rsp_blank;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = CSR_BLINK_HALF;
   logic [11:0] csr_wdata = '0;

   strip_frame_board board;
   int unsigned gap_pct = 31;
   int unsigned stall_pct = 62;
   int unsigned items_sent, effective_items, settings_used;
   int unsigned cycle_count;

   rgb_led_fade_blink_controller #(
      .DEFAULT_COLOUR(START_COLOUR),
      .DEFAULT_LEVEL(START_LEVEL)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_opcode(req_opcode),
      .req_red_in(req_red_in),
      .req_green_in(req_green_in),
      .req_blue_in(req_blue_in),
      .req_level(req_level),
      .req_fade_duration(req_fade_duration),
      .empty(empty),
      .pop(pop),
      .rsp_red_out(rsp_red_out),
      .rsp_green_out(rsp_green_out),
      .rsp_blue_out(rsp_blue_out),
      .rsp_blank(rsp_blank),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty)
            board.check_frame({rsp_red_out, rsp_green_out, rsp_blue_out, rsp_blank});
         pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_item(input logic [2:0] op, input logic [23:0] rgb,
                            input logic [7:0] lvl, input logic [15:0] dur);
      while ($urandom_range(99) < gap_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push              <= 1'b1;
      req_opcode        <= op;
      req_red_in        <= rgb[23:16];
      req_green_in      <= rgb[15:8];
      req_blue_in       <= rgb[7:0];
      req_level         <= lvl;
      req_fade_duration <= dur;
      @(posedge clock);
      while (full) @(posedge clock);
      items_sent++;
      if (board.note_item(op, rgb, lvl, dur)) effective_items++;
   endtask

   task automatic send_tick();
      send_item(OP_TICK, 24'($urandom), 8'($urandom), 16'($urandom));
   endtask

   // hold input until every due frame is out, then let queued items drain
   task automatic settle();
      push <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_timing(input logic [11:0] half, input logic [7:0] fstep,
                              input logic [11:0] idle_val);
      csr_write <= 1'b1;
      csr_index <= CSR_BLINK_HALF;
      csr_wdata <= half;
      @(posedge clock);
      board.write_reg(CSR_BLINK_HALF, half);
      csr_index <= CSR_FADE_STEP;
      csr_wdata <= {4'd0, fstep};
      @(posedge clock);
      board.write_reg(CSR_FADE_STEP, {4'd0, fstep});
      csr_index <= CSR_IDLE;
      csr_wdata <= idle_val;
      @(posedge clock);
      board.write_reg(CSR_IDLE, idle_val);
      csr_write <= 1'b0;
      settings_used++;
   endtask

   task automatic directed_items();
      send_item(OP_ON, 24'h000000, 8'd0, 16'd0);
      send_item(OP_INTENSITY, 24'h000000, 8'd255, 16'd0);
      send_item(OP_COLOUR, 24'hFF0080, 8'd0, 16'd0);
      send_item(OP_COLOUR, 24'h00FF00, 8'd0, 16'd0);
      send_item(OP_INTENSITY, 24'h000000, 8'd0, 16'd0);
      // colour while intensity is zero stays dark
      send_item(OP_COLOUR, 24'h123456, 8'd0, 16'd0);
      send_item(OP_ON, 24'h000000, 8'd0, 16'd0);
      send_item(OP_INTENSITY, 24'h000000, 8'd1, 16'd0);
      send_item(OP_ANIM, 24'h000000, 8'd3, 16'd0);
      send_item(OP_ANIM, 24'hFFFFFF, 8'd255, 16'hFFFF);
      send_item(OP_UNUSED, 24'hFFFFFF, 8'd255, 16'hFFFF);
      send_item(OP_TICK, 24'h000000, 8'd0, 16'd0);
      send_item(OP_OFF, 24'h000000, 8'd0, 16'd0);
      // blink shows the lit phase even while off
      send_item(OP_ANIM, 24'h000000, ANIM_BLINK, 16'd0);
      repeat (3) send_item(OP_TICK, 24'h000000, 8'd0, 16'd0);
      send_item(OP_INTENSITY, 24'h000000, 8'd200, 16'd0);
      // zero-length fade lands on the target at the next pass
      send_item(OP_FADE, 24'hFFFFFF, 8'd0, 16'd0);
      repeat (2) send_item(OP_TICK, 24'h000000, 8'd0, 16'd0);
      send_item(OP_ANIM, 24'h000000, ANIM_NONE, 16'd0);
      send_item(OP_ANIM, 24'h000000, ANIM_FADE, 16'd0);
      send_item(OP_TICK, 24'h000000, 8'd0, 16'd0);
      send_item(OP_FADE, 24'h000000, 8'd0, 16'hFFFF);
      send_item(OP_TICK, 24'h000000, 8'd0, 16'd0);
      send_item(OP_OFF, 24'h000000, 8'd0, 16'd0);
   endtask

   task automatic random_item();
      logic [2:0]  op;
      logic [23:0] rgb;
      logic [7:0]  lvl;
      logic [15:0] dur;
      int unsigned pick;
      rgb = 24'($urandom);
      lvl = 8'($urandom);
      dur = 16'($urandom_range(0, 48));
      if ($urandom_range(19) == 0) dur = 16'($urandom);
      if (board.runner_on && $urandom_range(99) < 75) begin
         op = OP_TICK;
      end else begin
         pick = $urandom_range(99);
         if (pick < 8) op = OP_TICK;
         else if (pick < 30) op = OP_ANIM;
         else if (pick < 52) op = OP_FADE;
         else if (pick < 64) op = OP_INTENSITY;
         else if (pick < 76) op = OP_COLOUR;
         else if (pick < 86) op = OP_ON;
         else if (pick < 95) op = OP_OFF;
         else op = OP_UNUSED;
      end
      if (op == OP_ANIM && $urandom_range(7) != 0) lvl = 8'($urandom_range(0, 2));
      if (op == OP_INTENSITY && $urandom_range(7) == 0) lvl = 8'd0;
      send_item(op, rgb, lvl, dur);
   endtask

   // long waits: two blink passes 200 ticks apart, then a three-frame fade
   // at the widest fade step
   task automatic long_waits();
      load_timing(12'd200, 8'hFF, 12'hFFF);
      send_item(OP_OFF, 24'($urandom), 8'($urandom), 16'($urandom));
      send_item(OP_ANIM, 24'($urandom), ANIM_BLINK, 16'($urandom));
      repeat (205) send_tick();
      send_item(OP_OFF, 24'($urandom), 8'($urandom), 16'($urandom));
      send_item(OP_ON, 24'($urandom), 8'($urandom), 16'($urandom));
      send_item(OP_FADE, 24'($urandom), 8'($urandom), 16'd510);
      repeat (520) send_tick();
      send_item(OP_ANIM, 24'($urandom), ANIM_NONE, 16'($urandom));
   endtask

   initial begin
      int unsigned quota;
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      load_timing(12'd2, 8'd3, 12'd2);
      directed_items();
      for (int ph = 0; ph < 6; ph++) begin
         gap_pct   = (ph < 2) ? 31 : (ph < 4) ? 62 : 0;
         stall_pct = (ph < 2) ? 62 : (ph < 4) ? 31 : 0;
         settle();
         case (ph)
            0: load_timing(12'd3, 8'd2, 12'd4);
            1: load_timing(12'($urandom_range(1, 16)), 8'($urandom_range(1, 6)),
                           12'($urandom_range(1, 16)));
            2: load_timing(12'd1, 8'd1, 12'd1);
            3: load_timing(12'd0, 8'd0, 12'd0);
            4: load_timing(12'($urandom_range(1, 16)), 8'($urandom_range(1, 6)),
                           12'($urandom_range(1, 16)));
            default: load_timing(12'($urandom_range(1, 40)), 8'($urandom_range(1, 10)),
                                 12'($urandom_range(1, 40)));
         endcase
         quota = effective_items + PHASE_ITEMS;
         while (effective_items < quota) begin
            random_item();
            if ($urandom_range(199) == 0) settle();
         end
      end
      settle();
      long_waits();
      settle();
      $display("Sent %0d items (%0d acted on) over %0d timing settings; checked %0d frames",
               items_sent, effective_items, settings_used, board.frames_checked);
      $display("Frames: %0d blank, %0d blink passes, %0d fade steps, %0d fades completed",
               board.blanks, board.blink_passes, board.fade_frames, board.fade_ends);
      if (board.errors == 0 && board.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/rlfb_pkg.sv
sv/rlfb_fifo.sv
sv/rlfb_front.sv
sv/rlfb_back.sv
sv/rgb_led_fade_blink_controller.sv
sv/rlfb_checker.sv
verif/rgb_led_fade_blink_controller_test.sv
